// ----- hw/rtl/tempo_synced_phase_clock_assert.svh -----
// assertion helpers for the tempo synced phase clock
// both expect clk and arst_n in the scope of use
`ifndef TEMPO_SYNCED_PHASE_CLOCK_ASSERT_SVH
`define TEMPO_SYNCED_PHASE_CLOCK_ASSERT_SVH

// consequent checked in the same cycle
`define TSPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define TSPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tspc_pkg.sv -----
`timescale 1ns / 1ps

package tspc_pkg;

	localparam int TICKS_PER_QUARTER = 1920;

	// field widths
	localparam int UT_W       = 16;
	localparam int SR_W       = 18;
	localparam int BPM_W      = 16;
	localparam int PSTEP_W    = 24;
	localparam int BV_W       = 7;
	localparam int MOD_W      = 16;
	localparam int INC_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// datapath widths
	localparam int LEN_W   = 40;
	localparam int FRAC_W  = 16;
	localparam int FAC_W   = 21;
	localparam int BVSR_W  = BV_W + SR_W;
	localparam int REM_W   = 66;
	localparam int OP_W    = 65;
	localparam int DQ_W    = 64;
	localparam int STEPS_W = $clog2(DQ_W + 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_QUARTER_VALUE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNAP_SIZE     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_ONE_DEPTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOD_TWO_DEPTH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 3'd5;

	// register reset values
	localparam logic [UT_W-1:0] RST_QUARTER_VALUE = 16'd96;
	localparam logic [UT_W-1:0] RST_BASE_LENGTH   = 16'd96;
	localparam logic [UT_W-1:0] RST_SNAP_SIZE     = 16'd0;
	localparam logic [UT_W-1:0] RST_DEPTH         = 16'd2048;
	localparam logic [SR_W-1:0] RST_SAMPLE_RATE   = 18'd48000;

	localparam logic [UT_W-1:0]  DEPTH_ONE = 16'd2048;
	localparam logic [FAC_W-1:0] FAC_ONE   = 21'h10000;
	localparam logic [LEN_W-1:0] LEN_MAX   = '1;
	localparam logic [INC_W-1:0] INC_MAX   = '1;

	typedef struct packed {
		logic [UT_W-1:0] quarter_value;
		logic [UT_W-1:0] base_length;
		logic [UT_W-1:0] snap_size;
		logic [UT_W-1:0] mod_one_depth;
		logic [UT_W-1:0] mod_two_depth;
		logic [SR_W-1:0] sample_rate;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic               is_div;
		logic [STEPS_W-1:0] steps;
		logic [REM_W-1:0]   rem_init;
		logic [DQ_W-1:0]    dq_init;
		logic [OP_W-1:0]    op;
	} alu_cmd_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [REM_W-1:0] rem;
		logic [DQ_W-1:0]  quo;
	} alu_rsp_t;

	function automatic logic [LEN_W-1:0] sat_len(input logic [DQ_W-1:0] v);
		return (|v[DQ_W-1:LEN_W]) ? LEN_MAX : v[LEN_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/tspc_if.sv -----
`timescale 1ns / 1ps

interface tspc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tspc_pkg::CFG_IDX_W-1:0]    index;
	logic [tspc_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

interface tspc_sample_if;
	logic                              valid;
	logic                              ready;
	logic [tspc_pkg::BPM_W-1:0]        tempo_bpm;
	logic [tspc_pkg::PSTEP_W-1:0]      position_step;
	logic [tspc_pkg::BV_W-1:0]         beat_value;
	logic                              sync_trigger;
	logic signed [tspc_pkg::MOD_W-1:0] mod_one;
	logic signed [tspc_pkg::MOD_W-1:0] mod_two;

	modport source (output valid, tempo_bpm, position_step, beat_value, sync_trigger,
		mod_one, mod_two, input ready);
	modport sink (input valid, tempo_bpm, position_step, beat_value, sync_trigger,
		mod_one, mod_two, output ready);
endinterface

interface tspc_result_if;
	logic                              valid;
	logic                              ready;
	logic                              period_trigger;
	logic [tspc_pkg::INC_W-1:0]        phase_increment;

	modport source (output valid, period_trigger, phase_increment, input ready);
	modport sink (input valid, period_trigger, phase_increment, output ready);
endinterface

// ----- hw/rtl/tspc_alu.sv -----
`timescale 1ns / 1ps

// one bit per cycle: restoring divide or shift-add multiply on a single adder
module tspc_alu (
	input  logic                clk,
	input  logic                arst_n,
	input  tspc_pkg::alu_cmd_t  cmd,
	output tspc_pkg::alu_rsp_t  rsp
);

	localparam int REM_W   = tspc_pkg::REM_W;
	localparam int OP_W    = tspc_pkg::OP_W;
	localparam int DQ_W    = tspc_pkg::DQ_W;
	localparam int STEPS_W = tspc_pkg::STEPS_W;

	logic [REM_W-1:0]   rem_q;
	logic [DQ_W-1:0]    dq_q;
	logic [OP_W-1:0]    op_q;
	logic               is_div_q;
	logic               busy_q;
	logic               done_q;
	logic [STEPS_W-1:0] cnt_q;

	logic [REM_W-1:0] shifted;
	logic [REM_W:0]   addend;
	logic [REM_W:0]   res;
	logic             qbit;
	logic             add_en;
	logic [REM_W-1:0] rem_nxt;
	logic [DQ_W-1:0]  dq_nxt;

	always_comb begin
		// divide shifts the next dividend bit in, multiply shifts a zero in
		shifted = {rem_q[REM_W-2:0], is_div_q & dq_q[DQ_W-1]};
		addend  = {{(REM_W + 1 - OP_W){1'b0}}, op_q};
		if (is_div_q) begin
			addend = ~addend;
		end
		res     = {1'b0, shifted} + addend + (REM_W + 1)'(is_div_q);
		qbit    = is_div_q & ~res[REM_W];
		add_en  = is_div_q ? qbit : dq_q[DQ_W-1];
		rem_nxt = add_en ? res[REM_W-1:0] : shifted;
		dq_nxt  = {dq_q[DQ_W-2:0], qbit};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEPS_W'(1);
				if (cnt_q == STEPS_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q    <= cmd.rem_init;
			dq_q     <= cmd.dq_init;
			op_q     <= cmd.op;
			is_div_q <= cmd.is_div;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dq_q  <= dq_nxt;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;
	assign rsp.quo  = dq_q;

endmodule

// ----- hw/rtl/tspc_seq.sv -----
`timescale 1ns / 1ps

module tspc_seq #(
	parameter int TICKS_PER_QUARTER = tspc_pkg::TICKS_PER_QUARTER
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tspc_pkg::cfg_t     cfg,
	tspc_sample_if.sink        samples,
	tspc_result_if.source      results,
	output tspc_pkg::alu_cmd_t alu_cmd,
	input  tspc_pkg::alu_rsp_t alu_rsp
);

	localparam int UT_W     = tspc_pkg::UT_W;
	localparam int LEN_W    = tspc_pkg::LEN_W;
	localparam int FRAC_W   = tspc_pkg::FRAC_W;
	localparam int FAC_W    = tspc_pkg::FAC_W;
	localparam int BVSR_W   = tspc_pkg::BVSR_W;
	localparam int REM_W    = tspc_pkg::REM_W;
	localparam int OP_W     = tspc_pkg::OP_W;
	localparam int DQ_W     = tspc_pkg::DQ_W;
	localparam int STEPS_W  = tspc_pkg::STEPS_W;
	localparam int INC_W    = tspc_pkg::INC_W;
	localparam int MOD_W    = tspc_pkg::MOD_W;

	localparam int TPQ_W     = $clog2(TICKS_PER_QUARTER + 1);
	localparam int TK_W      = UT_W + TPQ_W;
	localparam int TK_DIV_W  = TK_W + FRAC_W;
	localparam int K24       = 24 * TICKS_PER_QUARTER;
	localparam int K24_W     = $clog2(K24 + 1);
	localparam int NUM_W     = tspc_pkg::BPM_W + K24_W;
	localparam int MOD_DIV_W = LEN_W + FRAC_W;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_POS   = 5'd1;
	localparam logic [4:0] S_L0    = 5'd2;
	localparam logic [4:0] S_L0W   = 5'd3;
	localparam logic [4:0] S_FAC   = 5'd4;
	localparam logic [4:0] S_MOD   = 5'd5;
	localparam logic [4:0] S_MODW  = 5'd6;
	localparam logic [4:0] S_GRID  = 5'd7;
	localparam logic [4:0] S_GRIDW = 5'd8;
	localparam logic [4:0] S_SNAP  = 5'd9;
	localparam logic [4:0] S_SNAPW = 5'd10;
	localparam logic [4:0] S_FIX   = 5'd11;
	localparam logic [4:0] S_BVSR  = 5'd12;
	localparam logic [4:0] S_DMUL  = 5'd13;
	localparam logic [4:0] S_DMULW = 5'd14;
	localparam logic [4:0] S_DCHK  = 5'd15;
	localparam logic [4:0] S_DDIVW = 5'd16;
	localparam logic [4:0] S_DONE  = 5'd17;

	logic [4:0]                      state_q;
	logic [LEN_W-1:0]                position_q;
	logic [LEN_W-1:0]                period_q;
	logic [LEN_W-1:0]                len_q;
	logic [LEN_W-1:0]                grid_q;
	logic                            trig_q;
	logic                            sel_q;
	logic                            neg_q;
	logic                            sync_q;
	logic [tspc_pkg::BPM_W-1:0]      bpm_q;
	logic [tspc_pkg::PSTEP_W-1:0]    pstep_q;
	logic [tspc_pkg::BV_W-1:0]       bv_q;
	logic [MOD_W-1:0]                m1_q;
	logic [MOD_W-1:0]                m2_q;
	logic [FAC_W-1:0]                fac_q;
	logic [BVSR_W-1:0]               bvsr_q;
	logic [NUM_W-1:0]                num_q;
	logic [OP_W-1:0]                 prod_q;
	logic [INC_W-1:0]                inc_q;
	logic                            ovalid_q;
	logic                            otrig_q;
	logic [INC_W-1:0]                oinc_q;

	logic [UT_W-1:0]  q_eff;
	logic [TK_W-1:0]  note_ticks;
	logic [TK_W-1:0]  snap_ticks;
	logic [LEN_W-1:0] pos_sel;
	logic [LEN_W:0]   pos_diff;
	logic [UT_W-1:0]  depth_sel;
	logic [UT_W-1:0]  depth_ex;
	logic [MOD_W-1:0] m_sel;
	logic [MOD_W-1:0] m_mag;
	logic [31:0]      fac_prod;
	logic [FAC_W-1:0] fac_nxt;
	logic [LEN_W-1:0] mod_len;
	logic             num_ge;
	logic             inc_zero;

	always_comb begin
		q_eff      = (cfg.quarter_value == '0) ? UT_W'(1) : cfg.quarter_value;
		note_ticks = TK_W'(cfg.base_length) * TK_W'(TICKS_PER_QUARTER);
		snap_ticks = TK_W'(cfg.snap_size) * TK_W'(TICKS_PER_QUARTER);

		// sync forces the position onto the period end
		pos_sel  = sync_q ? period_q : position_q;
		pos_diff = {1'b0, pos_sel} - {1'b0, period_q};

		depth_sel = sel_q ? cfg.mod_two_depth : cfg.mod_one_depth;
		depth_ex  = (depth_sel < tspc_pkg::DEPTH_ONE) ? '0 : depth_sel - tspc_pkg::DEPTH_ONE;
		m_sel     = sel_q ? m2_q : m1_q;
		m_mag     = m_sel[MOD_W-1] ? (~m_sel + MOD_W'(1)) : m_sel;
		fac_prod  = depth_ex * m_mag;
		fac_nxt   = FAC_W'(fac_prod >> 10) + tspc_pkg::FAC_ONE;

		if (neg_q) begin
			mod_len = alu_rsp.quo[LEN_W-1:0];
		end else if (|alu_rsp.rem[REM_W-1:MOD_DIV_W]) begin
			mod_len = tspc_pkg::LEN_MAX;
		end else begin
			mod_len = alu_rsp.rem[MOD_DIV_W-1:FRAC_W];
		end

		num_ge   = REM_W'({num_q, 1'b0}) >= REM_W'(prod_q);
		inc_zero = (bvsr_q == '0) || (period_q == '0);
	end

	always_comb begin
		alu_cmd          = '0;
		alu_cmd.is_div   = 1'b1;
		unique case (state_q)
			S_L0: begin
				alu_cmd.start   = 1'b1;
				alu_cmd.steps   = STEPS_W'(TK_DIV_W);
				alu_cmd.dq_init = DQ_W'({note_ticks, {FRAC_W{1'b0}}}) << (DQ_W - TK_DIV_W);
				alu_cmd.op      = OP_W'(q_eff);
			end
			S_MOD: begin
				alu_cmd.start = 1'b1;
				if (neg_q) begin
					alu_cmd.steps   = STEPS_W'(MOD_DIV_W);
					alu_cmd.dq_init = DQ_W'(len_q) << (DQ_W - LEN_W);
					alu_cmd.op      = OP_W'(fac_q);
				end else begin
					alu_cmd.is_div  = 1'b0;
					alu_cmd.steps   = STEPS_W'(FAC_W);
					alu_cmd.dq_init = DQ_W'(fac_q) << (DQ_W - FAC_W);
					alu_cmd.op      = OP_W'(len_q);
				end
			end
			S_GRID: begin
				alu_cmd.start   = 1'b1;
				alu_cmd.steps   = STEPS_W'(TK_DIV_W);
				alu_cmd.dq_init = DQ_W'({snap_ticks, {FRAC_W{1'b0}}}) << (DQ_W - TK_DIV_W);
				alu_cmd.op      = OP_W'(q_eff);
			end
			S_SNAP: begin
				alu_cmd.start   = (grid_q != '0);
				alu_cmd.steps   = STEPS_W'(LEN_W);
				alu_cmd.dq_init = DQ_W'(len_q) << (DQ_W - LEN_W);
				alu_cmd.op      = OP_W'(grid_q);
			end
			S_DMUL: begin
				alu_cmd.start   = ~inc_zero;
				alu_cmd.is_div  = 1'b0;
				alu_cmd.steps   = STEPS_W'(BVSR_W);
				alu_cmd.dq_init = DQ_W'(bvsr_q) << (DQ_W - BVSR_W);
				alu_cmd.op      = OP_W'(period_q);
			end
			S_DCHK: begin
				// low 32 dividend bits are zero, the upper part seeds the remainder
				alu_cmd.start    = ~num_ge;
				alu_cmd.steps    = STEPS_W'(INC_W);
				alu_cmd.rem_init = REM_W'({num_q, 1'b0});
				alu_cmd.op       = prod_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			position_q <= '0;
			period_q   <= '0;
			trig_q     <= 1'b0;
			sel_q      <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (state_q == S_DONE && (!ovalid_q || results.ready)) begin
				ovalid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					trig_q     <= ~pos_diff[LEN_W];
					position_q <= pos_diff[LEN_W] ? pos_sel : pos_diff[LEN_W-1:0];
					state_q    <= pos_diff[LEN_W] ? S_BVSR : S_L0;
				end
				S_L0: begin
					state_q <= S_L0W;
				end
				S_L0W: begin
					if (alu_rsp.done) begin
						sel_q   <= 1'b0;
						state_q <= S_FAC;
					end
				end
				S_FAC: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					state_q <= S_MODW;
				end
				S_MODW: begin
					if (alu_rsp.done) begin
						if (!sel_q) begin
							sel_q   <= 1'b1;
							state_q <= S_FAC;
						end else if (cfg.snap_size != '0) begin
							state_q <= S_GRID;
						end else begin
							period_q <= mod_len;
							state_q  <= S_BVSR;
						end
					end
				end
				S_GRID: begin
					state_q <= S_GRIDW;
				end
				S_GRIDW: begin
					if (alu_rsp.done) begin
						state_q <= S_SNAP;
					end
				end
				S_SNAP: begin
					if (grid_q == '0) begin
						period_q <= len_q;
						state_q  <= S_BVSR;
					end else begin
						state_q <= S_SNAPW;
					end
				end
				S_SNAPW: begin
					if (alu_rsp.done) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					// snapped to zero means one whole grid step
					period_q <= (len_q == '0) ? grid_q : len_q;
					state_q  <= S_BVSR;
				end
				S_BVSR: begin
					position_q <= position_q + LEN_W'(pstep_q);
					state_q    <= S_DMUL;
				end
				S_DMUL: begin
					state_q <= inc_zero ? S_DONE : S_DMULW;
				end
				S_DMULW: begin
					if (alu_rsp.done) begin
						state_q <= S_DCHK;
					end
				end
				S_DCHK: begin
					state_q <= num_ge ? S_DONE : S_DDIVW;
				end
				S_DDIVW: begin
					if (alu_rsp.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ovalid_q || results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (samples.valid) begin
					bpm_q   <= samples.tempo_bpm;
					pstep_q <= samples.position_step;
					bv_q    <= samples.beat_value;
					sync_q  <= samples.sync_trigger;
					m1_q    <= $unsigned(samples.mod_one);
					m2_q    <= $unsigned(samples.mod_two);
				end
			end
			S_L0W: begin
				if (alu_rsp.done) begin
					len_q <= tspc_pkg::sat_len(alu_rsp.quo);
				end
			end
			S_FAC: begin
				fac_q <= fac_nxt;
				neg_q <= m_sel[MOD_W-1];
			end
			S_MODW: begin
				if (alu_rsp.done) begin
					len_q <= mod_len;
				end
			end
			S_GRIDW: begin
				if (alu_rsp.done) begin
					grid_q <= tspc_pkg::sat_len(alu_rsp.quo);
				end
			end
			S_SNAPW: begin
				if (alu_rsp.done) begin
					len_q <= len_q - alu_rsp.rem[LEN_W-1:0];
				end
			end
			S_BVSR: begin
				bvsr_q <= BVSR_W'(bv_q) * BVSR_W'(cfg.sample_rate);
				num_q  <= NUM_W'(bpm_q) * NUM_W'(K24);
			end
			S_DMUL: begin
				if (inc_zero) begin
					inc_q <= tspc_pkg::INC_MAX;
				end
			end
			S_DMULW: begin
				if (alu_rsp.done) begin
					prod_q <= alu_rsp.rem[OP_W-1:0];
				end
			end
			S_DCHK: begin
				if (num_ge) begin
					inc_q <= tspc_pkg::INC_MAX;
				end
			end
			S_DDIVW: begin
				if (alu_rsp.done) begin
					inc_q <= alu_rsp.quo[INC_W-1:0];
				end
			end
			S_DONE: begin
				if (!ovalid_q || results.ready) begin
					otrig_q <= trig_q;
					oinc_q  <= inc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign samples.ready           = (state_q == S_IDLE);
	assign results.valid           = ovalid_q;
	assign results.period_trigger  = otrig_q;
	assign results.phase_increment = oinc_q;

endmodule

// ----- hw/rtl/tempo_synced_phase_clock.sv -----
`timescale 1ns / 1ps
// channel   dir     one beat carries
// cfg       sink    register index and write data, always ready
// samples   sink    tempo, position step, beat value, sync, two modulations
// results   source  period trigger and phase increment, one per sample
//
// with no period end a sample needs only the increment multiply and divide; a
// period end adds the length chain before them
// all arithmetic shares one add/subtract unit taking one quotient or
// multiplier bit per cycle
// samples is ready only while the sequencer idles; a held result stalls it
// reset clears position, period length and the registers to their defaults

`include "tempo_synced_phase_clock_assert.svh"

module tempo_synced_phase_clock #(
	parameter int TICKS_PER_QUARTER = tspc_pkg::TICKS_PER_QUARTER
) (
	input  logic          clk,
	input  logic          arst_n,
	tspc_cfg_if.sink      cfg,
	tspc_sample_if.sink   samples,
	tspc_result_if.source results
);

	tspc_pkg::cfg_t     cfg_q;
	tspc_pkg::alu_cmd_t alu_cmd;
	tspc_pkg::alu_rsp_t alu_rsp;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quarter_value <= tspc_pkg::RST_QUARTER_VALUE;
			cfg_q.base_length   <= tspc_pkg::RST_BASE_LENGTH;
			cfg_q.snap_size     <= tspc_pkg::RST_SNAP_SIZE;
			cfg_q.mod_one_depth <= tspc_pkg::RST_DEPTH;
			cfg_q.mod_two_depth <= tspc_pkg::RST_DEPTH;
			cfg_q.sample_rate   <= tspc_pkg::RST_SAMPLE_RATE;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				tspc_pkg::REG_QUARTER_VALUE: cfg_q.quarter_value <= cfg.data[tspc_pkg::UT_W-1:0];
				tspc_pkg::REG_BASE_LENGTH:   cfg_q.base_length   <= cfg.data[tspc_pkg::UT_W-1:0];
				tspc_pkg::REG_SNAP_SIZE:     cfg_q.snap_size     <= cfg.data[tspc_pkg::UT_W-1:0];
				tspc_pkg::REG_MOD_ONE_DEPTH: cfg_q.mod_one_depth <= cfg.data[tspc_pkg::UT_W-1:0];
				tspc_pkg::REG_MOD_TWO_DEPTH: cfg_q.mod_two_depth <= cfg.data[tspc_pkg::UT_W-1:0];
				tspc_pkg::REG_SAMPLE_RATE:   cfg_q.sample_rate   <= cfg.data[tspc_pkg::SR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tspc_seq #(
		.TICKS_PER_QUARTER(TICKS_PER_QUARTER)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.samples (samples),
		.results (results),
		.alu_cmd (alu_cmd),
		.alu_rsp (alu_rsp)
	);

	tspc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.rsp    (alu_rsp)
	);

	`TSPC_ASSERT_NEXT(a_busy_after_beat, samples.valid && samples.ready, !samples.ready, "ready after beat")
	`TSPC_ASSERT_SAME(a_alu_free_on_start, alu_cmd.start, !alu_rsp.busy, "alu started while busy")
	`TSPC_ASSERT_NEXT(a_alu_runs_after_start, alu_cmd.start, alu_rsp.busy && !alu_rsp.done, "alu idle after start")

endmodule
